[src/tacvs_pkg.sv]
`default_nettype none

package tacvs_pkg;

   // element and result index widths
   localparam int DATA_W = 32;
   localparam int IDX_W  = 6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FETCH_A,
      S_FETCH_B,
      S_CMP_AB,
      S_FETCH_C,
      S_CMP_C,
      S_PUT
   } state_type;

endpackage

`default_nettype wire

[src/three_array_common_value_search_top.sv]
`default_nettype none

// Common value search over three arrays.
// Request channel (req_valid / req_stall): each accepted request writes one
// position of all three arrays, in order from position 0. The request with
// req_last high ends the load and starts the search. Requests past MAX_LEN
// positions are dropped; only the first MAX_LEN positions are searched.
// Requests are taken one per cycle while the block loads. The channel stalls
// from the last request until the search result enters the response slot.
// Response channel (rsp_valid / rsp_stall): one response per load, carrying
// the flag rsp_found and the first (i, j, k) in lexicographic order where
// all three values are equal; all indices are zero when nothing matches.
// The search walks the three arrays through one registered read port per
// array. Each i fetches one value of the first array, each j tried fetches
// one value of the second and compares it, and each k scanned after a
// first/second match fetches one value of the third and compares it.
// Reset clears the sequencer, the load count and the response valid. Array
// contents are not cleared; a load only reads what it wrote. A response
// held by rsp_stall stays stable; the block loads the next array set while
// it waits and holds a finished search until the response slot frees.
module three_array_common_value_search_top #(
   parameter int MAX_LEN = 64
) (
   input  wire                              clock,
   input  wire                              reset,

   input  wire                              req_valid,
   output logic                             req_stall,
   input  wire  signed [tacvs_pkg::DATA_W-1:0] req_value_first,
   input  wire  signed [tacvs_pkg::DATA_W-1:0] req_value_second,
   input  wire  signed [tacvs_pkg::DATA_W-1:0] req_value_third,
   input  wire                              req_last,

   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output logic                             rsp_found,
   output logic [tacvs_pkg::IDX_W-1:0]      rsp_first_index,
   output logic [tacvs_pkg::IDX_W-1:0]      rsp_second_index,
   output logic [tacvs_pkg::IDX_W-1:0]      rsp_third_index
);

   localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int CNT_W  = $clog2(MAX_LEN + 1);
   localparam int WIDE_W = (ADDR_W > tacvs_pkg::IDX_W) ? ADDR_W : tacvs_pkg::IDX_W;

   // array stores, one write and one read port each
   logic [tacvs_pkg::DATA_W-1:0] mem_a [MAX_LEN];
   logic [tacvs_pkg::DATA_W-1:0] mem_b [MAX_LEN];
   logic [tacvs_pkg::DATA_W-1:0] mem_c [MAX_LEN];
   logic [tacvs_pkg::DATA_W-1:0] a_ff, b_ff, c_ff;

   tacvs_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]  load_count_ff, load_count_in;
   logic [CNT_W-1:0]  len_ff, len_in;
   logic [ADDR_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic              found_ff, found_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic [tacvs_pkg::IDX_W-1:0] rsp_i_ff, rsp_j_ff, rsp_k_ff;

   logic req_acc, store_en, rsp_load, adv_j;
   logic last_i, last_j, last_k;
   logic [CNT_W-1:0]  sat_count;
   logic [WIDE_W-1:0] i_wide, j_wide, k_wide;

   assign req_stall = (state_ff != tacvs_pkg::S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign store_en  = req_acc && (load_count_ff < CNT_W'(MAX_LEN));
   assign sat_count = store_en ? (load_count_ff + CNT_W'(1)) : load_count_ff;

   assign last_i = (CNT_W'(i_ff) + CNT_W'(1)) == len_ff;
   assign last_j = (CNT_W'(j_ff) + CNT_W'(1)) == len_ff;
   assign last_k = (CNT_W'(k_ff) + CNT_W'(1)) == len_ff;

   // load writes at the count; search reads follow the position counters
   always_ff @(posedge clock) begin
      if (store_en) begin
         mem_a[load_count_ff[ADDR_W-1:0]] <= req_value_first;
         mem_b[load_count_ff[ADDR_W-1:0]] <= req_value_second;
         mem_c[load_count_ff[ADDR_W-1:0]] <= req_value_third;
      end
      a_ff <= mem_a[i_ff];
      b_ff <= mem_b[j_ff];
      c_ff <= mem_c[k_ff];
   end

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      len_in        = len_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      found_in      = found_ff;
      rsp_load      = 1'b0;
      adv_j         = 1'b0;
      case (state_ff)
         tacvs_pkg::S_IDLE: begin
            if (req_acc) begin
               if (req_last) begin
                  len_in        = sat_count;
                  load_count_in = '0;
                  i_in          = '0;
                  j_in          = '0;
                  k_in          = '0;
                  state_in      = tacvs_pkg::S_FETCH_A;
               end else begin
                  load_count_in = sat_count;
               end
            end
         end
         tacvs_pkg::S_FETCH_A: state_in = tacvs_pkg::S_FETCH_B;
         tacvs_pkg::S_FETCH_B: state_in = tacvs_pkg::S_CMP_AB;
         tacvs_pkg::S_CMP_AB: begin
            if (a_ff == b_ff) begin
               k_in     = '0;
               state_in = tacvs_pkg::S_FETCH_C;
            end else begin
               adv_j = 1'b1;
            end
         end
         tacvs_pkg::S_FETCH_C: state_in = tacvs_pkg::S_CMP_C;
         tacvs_pkg::S_CMP_C: begin
            if (b_ff == c_ff) begin
               found_in = 1'b1;
               state_in = tacvs_pkg::S_PUT;
            end else if (!last_k) begin
               k_in     = k_ff + ADDR_W'(1);
               state_in = tacvs_pkg::S_FETCH_C;
            end else begin
               adv_j = 1'b1;
            end
         end
         tacvs_pkg::S_PUT: begin
            // wait for a free response slot
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = tacvs_pkg::S_IDLE;
            end
         end
         default: state_in = tacvs_pkg::S_IDLE;
      endcase

      // step to the next (i, j) pair, or finish with no match
      if (adv_j) begin
         if (!last_j) begin
            j_in     = j_ff + ADDR_W'(1);
            state_in = tacvs_pkg::S_FETCH_B;
         end else if (!last_i) begin
            i_in     = i_ff + ADDR_W'(1);
            j_in     = '0;
            state_in = tacvs_pkg::S_FETCH_A;
         end else begin
            found_in = 1'b0;
            state_in = tacvs_pkg::S_PUT;
         end
      end

      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tacvs_pkg::S_IDLE;
         load_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign i_wide = WIDE_W'(i_ff);
   assign j_wide = WIDE_W'(j_ff);
   assign k_wide = WIDE_W'(k_ff);

   always_ff @(posedge clock) begin
      len_ff   <= len_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      found_ff <= found_in;
      if (rsp_load) begin
         rsp_found_ff <= found_ff;
         rsp_i_ff     <= found_ff ? i_wide[tacvs_pkg::IDX_W-1:0] : '0;
         rsp_j_ff     <= found_ff ? j_wide[tacvs_pkg::IDX_W-1:0] : '0;
         rsp_k_ff     <= found_ff ? k_wide[tacvs_pkg::IDX_W-1:0] : '0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_first_index  = rsp_i_ff;
   assign rsp_second_index = rsp_j_ff;
   assign rsp_third_index  = rsp_k_ff;

   // last request always launches a search
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_last) |=> (state_ff == tacvs_pkg::S_FETCH_A))
      else $error("search did not start after last request");

   // load count is cleared for the whole search
   a_count_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tacvs_pkg::S_IDLE) |-> (load_count_ff == '0))
      else $error("load count nonzero during search");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= CNT_W'(MAX_LEN))
      else $error("load count past MAX_LEN");

   // a miss reports zero indices
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |->
         (rsp_i_ff == '0 && rsp_j_ff == '0 && rsp_k_ff == '0))
      else $error("miss response with nonzero index");

   // a finished search never overwrites a pending response
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !rsp_load)
      else $error("pending response overwritten");

endmodule

`default_nettype wire
